>>> rtl/abpf_pkg.sv
// package: format mode codes, fixed-point constants and pipeline types for the alpha blender
`timescale 1ns / 1ps

package abpf_pkg;

  localparam logic [1:0] MODE_RGBA8_RGBA8  = 2'd0;
  localparam logic [1:0] MODE_RGBA8_RGB8   = 2'd1;
  localparam logic [1:0] MODE_RGBA8_RGB565 = 2'd2;
  localparam logic [1:0] MODE_RGBA4_RGB565 = 2'd3;

  localparam logic       REG_FORMAT_MODE  = 1'b0;
  localparam logic       REG_GLOBAL_ALPHA = 1'b1;

  localparam logic [7:0]  GLOBAL_ALPHA_RESET = 8'd255;
  localparam logic [15:0] WEIGHT16_ONE       = 16'hFFFF;
  localparam logic [15:0] WEIGHT8_ONE        = 16'd255;

  // reciprocal of 15 in q15, exact floor for numerators below 3826
  localparam logic [11:0] DIV15_MUL   = 12'd2185;
  localparam int          DIV15_SHIFT = 15;

  localparam int NUM_LANES = 3;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] wn;
    logic        nz;
  } weight_t;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] wn;
    logic [7:0]  x;
    logic [7:0]  y;
  } lane_op_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] word;
    logic        last;
  } dst_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] rgba4_hi;
  } src_t;

endpackage

>>> rtl/alpha_blend_pixel_formats_core.sv
// top level: alpha blend of one pixel per clock while the output is not stalled, in four pixel format modes
//
//   channel  ports       handshake     content
//   input    in_*        valid/ready   source and destination pixel, row end flag
//   output   out_*       valid/ready   blended pixel, blend flag, row end flag
//   config   cfg_*       write enable  format_mode (index 0), global_alpha (index 1)
//
// pipeline stages: alpha product, weight with divide by 15, lane products, sum and format
// one transaction per clock sustained while out_ready is high; the lane multipliers set the stage depth
// synchronous active-low reset clears the stage valid bits and the config registers
// a stall at the output holds a full stage only while every later stage is full, empty stages keep filling
`timescale 1ns / 1ps

module alpha_blend_pixel_formats_core import abpf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,

  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,

  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_src_red,
  input  logic [7:0]    in_src_green,
  input  logic [7:0]    in_src_blue,
  input  logic [7:0]    in_src_alpha,
  input  logic [15:0]   in_src_rgba4_word,
  input  logic [7:0]    in_dst_red,
  input  logic [7:0]    in_dst_green,
  input  logic [7:0]    in_dst_blue,
  input  logic [7:0]    in_dst_alpha,
  input  logic [15:0]   in_dst_rgb565_word,
  input  logic          in_row_last,

  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic [7:0]    out_alpha,
  output logic [15:0]   out_rgb565_word,
  output logic          out_was_blended,
  output logic          out_last
);

  logic [1:0]  format_mode_r;
  logic [7:0]  global_alpha_r;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        en1, en2, en3, en4;

  logic [1:0]  m1_r, m2_r, m3_r, m4_r;
  src_t        src1_r;
  dst_t        dst1_r, dst2_r, dst3_r;

  logic [7:0]  x_nxt [NUM_LANES];
  logic [7:0]  y_nxt [NUM_LANES];
  logic [7:0]  x2_r  [NUM_LANES];
  logic [7:0]  y2_r  [NUM_LANES];

  weight_t     weight;
  logic        nz3_r;
  lane_op_t    lane_op [NUM_LANES];
  logic [23:0] lane_sum [NUM_LANES];

  logic [7:0]  red_nxt, green_nxt, blue_nxt;
  logic [15:0] word_nxt;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_mode_r  <= MODE_RGBA8_RGBA8;
      global_alpha_r <= GLOBAL_ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT_MODE:  format_mode_r  <= cfg_data[1:0];
        REG_GLOBAL_ALPHA: global_alpha_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables
  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en1) begin
      m1_r            <= format_mode_r;
      src1_r.red      <= in_src_red;
      src1_r.green    <= in_src_green;
      src1_r.blue     <= in_src_blue;
      src1_r.rgba4_hi <= in_src_rgba4_word[15:4];
      dst1_r.red      <= in_dst_red;
      dst1_r.green    <= in_dst_green;
      dst1_r.blue     <= in_dst_blue;
      dst1_r.alpha    <= in_dst_alpha;
      dst1_r.word     <= in_dst_rgb565_word;
      dst1_r.last     <= in_row_last;
    end
  end

  abpf_weight u_weight (
    .clk          (clk),
    .en1          (en1),
    .en2          (en2),
    .mode         (format_mode_r),
    .mode_s1      (m1_r),
    .global_alpha (global_alpha_r),
    .src_alpha    (in_src_alpha),
    .src_alpha4   (in_src_rgba4_word[3:0]),
    .weight       (weight)
  );

  // stage 2 lane operands, lane 0 is the top field of a 565 word
  always_comb begin
    unique case (m1_r)
      MODE_RGBA8_RGBA8,
      MODE_RGBA8_RGB8: begin
        x_nxt[0] = src1_r.red;
        x_nxt[1] = src1_r.green;
        x_nxt[2] = src1_r.blue;
        y_nxt[0] = dst1_r.red;
        y_nxt[1] = dst1_r.green;
        y_nxt[2] = dst1_r.blue;
      end
      MODE_RGBA8_RGB565: begin
        x_nxt[0] = src1_r.blue;
        x_nxt[1] = src1_r.green;
        x_nxt[2] = src1_r.red;
        y_nxt[0] = {dst1_r.word[15:11], 3'b0};
        y_nxt[1] = {dst1_r.word[10:5], 2'b0};
        y_nxt[2] = {dst1_r.word[4:0], 3'b0};
      end
      default: begin
        x_nxt[0] = {3'b0, src1_r.rgba4_hi[11:8], 1'b1};
        x_nxt[1] = {2'b0, src1_r.rgba4_hi[7:4], 2'b10};
        x_nxt[2] = {3'b0, src1_r.rgba4_hi[3:0], 1'b1};
        y_nxt[0] = {3'b0, dst1_r.word[15:11]};
        y_nxt[1] = {2'b0, dst1_r.word[10:5]};
        y_nxt[2] = {3'b0, dst1_r.word[4:0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      m2_r   <= m1_r;
      dst2_r <= dst1_r;
      x2_r   <= x_nxt;
      y2_r   <= y_nxt;
    end
  end

  // stage 3 lanes
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    assign lane_op[i].w  = weight.w;
    assign lane_op[i].wn = weight.wn;
    assign lane_op[i].x  = x2_r[i];
    assign lane_op[i].y  = y2_r[i];

    abpf_lane u_lane (
      .clk (clk),
      .en  (en3),
      .op  (lane_op[i]),
      .sum (lane_sum[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      m3_r   <= m2_r;
      nz3_r  <= weight.nz;
      dst3_r <= dst2_r;
    end
  end

  // stage 4 format select
  always_comb begin
    red_nxt   = 8'd0;
    green_nxt = 8'd0;
    blue_nxt  = 8'd0;
    word_nxt  = 16'd0;
    unique case (m3_r)
      MODE_RGBA8_RGBA8,
      MODE_RGBA8_RGB8: begin
        red_nxt   = nz3_r ? lane_sum[0][23:16] : dst3_r.red;
        green_nxt = nz3_r ? lane_sum[1][23:16] : dst3_r.green;
        blue_nxt  = nz3_r ? lane_sum[2][23:16] : dst3_r.blue;
      end
      MODE_RGBA8_RGB565: begin
        word_nxt = nz3_r ? {lane_sum[0][15:11], lane_sum[1][15:10], lane_sum[2][15:11]}
                         : dst3_r.word;
      end
      default: begin
        word_nxt = nz3_r ? {lane_sum[0][12:8], lane_sum[1][13:8], lane_sum[2][12:8]}
                         : dst3_r.word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      m4_r            <= m3_r;
      out_red         <= red_nxt;
      out_green       <= green_nxt;
      out_blue        <= blue_nxt;
      out_alpha       <= dst3_r.alpha;
      out_rgb565_word <= word_nxt;
      out_was_blended <= nz3_r;
      out_last        <= dst3_r.last;
    end
  end

  assign out_valid = v4_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_565_rgb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (m4_r == MODE_RGBA8_RGB565 || m4_r == MODE_RGBA4_RGB565)
    |-> out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0)
    else $error("rgb channels nonzero in a 565 mode");

  a_rgb_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (m4_r == MODE_RGBA8_RGBA8 || m4_r == MODE_RGBA8_RGB8)
    |-> out_rgb565_word == 16'd0)
    else $error("565 word nonzero in an rgb mode");

  a_weight8_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (m3_r == MODE_RGBA8_RGB565 || m3_r == MODE_RGBA4_RGB565)
    |-> $past(weight.w[15:8]) == 8'd0 || !$past(en3))
    else $error("8-bit weight out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && v3_r && v4_r && !out_ready |-> !in_ready)
    else $error("input taken while the pipeline is full and stalled");

endmodule

>>> rtl/abpf_weight.sv
// effective alpha: global alpha product, then per-mode weight and complement
`timescale 1ns / 1ps

module abpf_weight import abpf_pkg::*; (
  input  logic          clk,
  input  logic          en1,
  input  logic          en2,
  input  logic [1:0]    mode,
  input  logic [1:0]    mode_s1,
  input  logic [7:0]    global_alpha,
  input  logic [7:0]    src_alpha,
  input  logic [3:0]    src_alpha4,
  output weight_t       weight
);

  logic [15:0] a_raw_r;
  logic [7:0]  a_sel;
  logic [23:0] div_prod;
  logic [7:0]  a_div15;
  logic [15:0] w_sel;
  weight_t     weight_nxt;
  weight_t     weight_r;

  assign a_sel = (mode == MODE_RGBA4_RGB565) ? {4'b0, src_alpha4} : src_alpha;

  always_ff @(posedge clk) begin
    if (en1) begin
      a_raw_r <= global_alpha * a_sel;
    end
  end

  assign div_prod = a_raw_r[11:0] * DIV15_MUL;
  assign a_div15  = div_prod[DIV15_SHIFT +: 8];

  always_comb begin
    unique case (mode_s1)
      MODE_RGBA8_RGBA8,
      MODE_RGBA8_RGB8: begin
        w_sel         = a_raw_r;
        weight_nxt.wn = WEIGHT16_ONE - a_raw_r;
      end
      MODE_RGBA8_RGB565: begin
        w_sel         = {8'b0, a_raw_r[15:8]};
        weight_nxt.wn = WEIGHT8_ONE - {8'b0, a_raw_r[15:8]};
      end
      default: begin
        w_sel         = {8'b0, a_div15};
        weight_nxt.wn = WEIGHT8_ONE - {8'b0, a_div15};
      end
    endcase
    weight_nxt.w  = w_sel;
    weight_nxt.nz = (w_sel != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      weight_r <= weight_nxt;
    end
  end

  assign weight = weight_r;

endmodule

>>> rtl/abpf_lane.sv
// one color lane: registered source and destination products, then their sum
`timescale 1ns / 1ps

module abpf_lane import abpf_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  lane_op_t      op,
  output logic [23:0]   sum
);

  logic [23:0] prod_src_r;
  logic [23:0] prod_dst_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_src_r <= op.w * op.x;
      prod_dst_r <= op.wn * op.y;
    end
  end

  assign sum = prod_src_r + prod_dst_r;

endmodule
